// ===== hw/rtl/xsf_pkg.sv =====
package xsf_pkg;

    localparam int BlockBytesDef = 1024;
    localparam int CntW          = 11;
    localparam int CfgIdxW       = 1;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_CRC = 8'h43;

    localparam logic [CntW-1:0] SMALL_BLOCK = CntW'(128);
    localparam logic [CntW-1:0] BIG_BLOCK   = CntW'(1024);
    localparam logic [CntW-1:0] SMALL_LIMIT = CntW'(1024 - 128);
    localparam logic [4:0]      RETRY_DEF   = 5'd20;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_RX    = 3'd1;
    localparam logic [2:0] CMD_TMO   = 3'd2;
    localparam logic [2:0] CMD_DATA  = 3'd3;
    localparam logic [2:0] CMD_PULL  = 3'd4;
    localparam logic [2:0] CMD_EOF   = 3'd5;
    localparam logic [2:0] CMD_CAN   = 3'd6;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BUSY        = 3'd1;
    localparam logic [2:0] ST_NOT_STARTED = 3'd2;
    localparam logic [2:0] ST_CANCELLED   = 3'd3;
    localparam logic [2:0] ST_BAD_REPLY   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT     = 3'd5;
    localparam logic [2:0] ST_DONE        = 3'd6;

    localparam logic [CfgIdxW-1:0] REG_BLOCK_1K = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_RETRY    = 1'd1;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
        logic       crc_mode;
    } t_result;

    // CRC-16 CCITT, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/xsf_store.sv =====
module xsf_store
    import xsf_pkg::*;
#(
    parameter int BLOCK_BYTES = BlockBytesDef
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(BLOCK_BYTES)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic [$clog2(BLOCK_BYTES)-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);

    logic [7:0] r_mem [BLOCK_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/xsf_fsm.sv =====
module xsf_fsm
    import xsf_pkg::*;
#(
    parameter int BLOCK_BYTES = BlockBytesDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [2:0]                     i_command,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_block_1k,
    input  logic [4:0]                     i_retry_limit,
    input  logic [7:0]                     i_rd_data,
    output logic [$clog2(BLOCK_BYTES)-1:0] o_rd_addr,
    output logic                           o_wr_en,
    output logic [$clog2(BLOCK_BYTES)-1:0] o_wr_addr,
    output t_result                        o_result
);

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam logic [CntW-1:0] BLK = CntW'(BLOCK_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_START, PH_READY, PH_WAIT_ACK,
        PH_SENDING, PH_FLUSH_WAIT_ACK, PH_FLUSH_SENDING, PH_SEND_EOT
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_crc, n_crc;
    logic [7:0]      r_seq, n_seq, r_ack, n_ack;
    logic [CntW-1:0] r_fill, n_fill, r_emit, n_emit;
    logic [CntW-1:0] r_base, n_base, r_size, n_size;
    logic [15:0]     r_check, n_check;
    logic [4:0]      r_retry, n_retry;
    logic [8:0]      r_held, n_held;
    logic [1:0]      r_eot, n_eot;

    logic            want_begin, begin_flush, want_judge, judge_flush, do_idle;
    logic [7:0]      judge_b, seq_diff, tx_b, fb;
    logic [2:0]      status;
    logic            tx_v;
    logic [CntW:0]   last_pos, idx, base_sum, rd_full;
    logic [5:0]      retry_inc;
    logic            flushing;

    always_comb begin
        n_phase = r_phase; n_crc = r_crc; n_seq = r_seq; n_ack = r_ack;
        n_fill = r_fill; n_emit = r_emit; n_base = r_base; n_size = r_size;
        n_check = r_check; n_retry = r_retry; n_held = r_held; n_eot = r_eot;
        want_begin = 1'b0; begin_flush = 1'b0;
        want_judge = 1'b0; judge_flush = 1'b0; judge_b = i_rx_byte;
        do_idle = 1'b0;
        status = ST_OK; tx_v = 1'b0; tx_b = 8'h00; fb = 8'h00;
        o_wr_en = 1'b0;
        flushing = (r_phase == PH_FLUSH_SENDING);
        last_pos = {1'b0, r_size} + (r_crc ? (CntW+1)'(4) : (CntW+1)'(3));
        idx = {1'b0, r_base} + {1'b0, r_emit} - (CntW+1)'(3);
        retry_inc = {1'b0, r_retry} + 6'd1;
        base_sum = {1'b0, r_base} + {1'b0, r_size};

        if (i_accept) begin
            case (i_command)
                CMD_START: do_idle = 1'b1;
                CMD_RX: begin
                    if (r_phase == PH_WAIT_START) begin
                        if (i_rx_byte == CH_CAN) begin
                            do_idle = 1'b1;
                            status = ST_CANCELLED;
                        end else if (i_rx_byte == CH_CRC) begin
                            n_crc = 1'b1;
                            n_phase = PH_READY;
                        end else if (i_rx_byte == CH_NAK) begin
                            n_crc = 1'b0;
                            n_phase = PH_READY;
                        end
                    end else if (r_phase == PH_WAIT_ACK || r_phase == PH_FLUSH_WAIT_ACK) begin
                        want_judge = 1'b1;
                        judge_flush = (r_phase == PH_FLUSH_WAIT_ACK);
                    end else if (r_phase == PH_READY) begin
                        seq_diff = r_seq - r_ack;
                        if (seq_diff != 8'd0 && !seq_diff[7] && !r_held[8]) begin
                            n_held = {1'b1, i_rx_byte};
                        end
                    end
                end
                CMD_TMO: begin
                    if (r_phase == PH_WAIT_START) begin
                        if (retry_inc >= {1'b0, i_retry_limit}) begin
                            do_idle = 1'b1;
                            status = ST_TIMEOUT;
                        end else begin
                            n_retry = retry_inc[4:0];
                        end
                    end else if (r_phase == PH_WAIT_ACK || r_phase == PH_FLUSH_WAIT_ACK) begin
                        do_idle = 1'b1;
                        status = ST_TIMEOUT;
                    end
                end
                CMD_DATA: begin
                    if (r_phase == PH_IDLE || r_phase == PH_WAIT_START) begin
                        status = ST_NOT_STARTED;
                    end else if (r_phase != PH_READY) begin
                        status = ST_BUSY;
                    end else begin
                        o_wr_en = (r_fill < BLK);
                        n_fill = r_fill + CntW'(1);
                        if (n_fill >= r_size) begin
                            want_begin = 1'b1;
                        end
                    end
                end
                CMD_PULL: begin
                    if (r_phase == PH_SENDING || r_phase == PH_FLUSH_SENDING) begin
                        tx_v = 1'b1;
                        if (r_emit == CntW'(0)) begin
                            n_check = 16'h0000;
                            tx_b = (r_size == BIG_BLOCK) ? CH_STX : CH_SOH;
                        end else if (r_emit == CntW'(1)) begin
                            tx_b = r_seq;
                        end else if (r_emit == CntW'(2)) begin
                            tx_b = ~r_seq;
                        end else if ({1'b0, r_emit} < {1'b0, r_size} + (CntW+1)'(3)) begin
                            fb = (idx < {1'b0, r_fill} && idx < {1'b0, BLK}) ? i_rd_data : 8'h00;
                            tx_b = fb;
                            n_check = r_crc ? crc_byte(r_check, fb)
                                            : {8'h00, r_check[7:0] + fb};
                        end else if ({1'b0, r_emit} == {1'b0, r_size} + (CntW+1)'(3)) begin
                            tx_b = r_crc ? r_check[15:8] : r_check[7:0];
                        end else begin
                            tx_b = r_check[7:0];
                        end
                        if ({1'b0, r_emit} >= last_pos) begin
                            n_seq = r_seq + 8'd1;
                            n_emit = '0;
                            if (!flushing) begin
                                n_fill = '0;
                                n_phase = PH_READY;
                            end else begin
                                n_base = base_sum[CntW-1:0];
                                if (base_sum[CntW-1:0] < r_fill) begin
                                    want_begin = 1'b1;
                                    begin_flush = 1'b1;
                                end else begin
                                    n_eot = 2'd0;
                                    n_phase = PH_SEND_EOT;
                                end
                            end
                        end else begin
                            n_emit = r_emit + CntW'(1);
                        end
                    end else if (r_phase == PH_SEND_EOT) begin
                        tx_v = 1'b1;
                        tx_b = CH_EOT;
                        n_eot = r_eot + 2'd1;
                        if (n_eot == 2'd3) begin
                            do_idle = 1'b1;
                            status = ST_DONE;
                        end
                    end
                end
                CMD_EOF: begin
                    if (r_phase == PH_IDLE || r_phase == PH_WAIT_START) begin
                        status = ST_NOT_STARTED;
                    end else if (r_phase != PH_READY) begin
                        status = ST_BUSY;
                    end else if (r_fill == '0) begin
                        n_eot = 2'd0;
                        n_phase = PH_SEND_EOT;
                    end else begin
                        if (r_fill <= SMALL_LIMIT) begin
                            n_size = SMALL_BLOCK;
                        end
                        n_base = '0;
                        want_begin = 1'b1;
                        begin_flush = 1'b1;
                    end
                end
                CMD_CAN: begin
                    tx_v = 1'b1;
                    tx_b = CH_CAN;
                    do_idle = 1'b1;
                end
                default: ;
            endcase
        end

        // start the next block: judge a held reply, wait for one, or send
        if (want_begin) begin
            seq_diff = n_seq - n_ack;
            if (seq_diff != 8'd0 && !seq_diff[7]) begin
                if (n_held[8]) begin
                    want_judge = 1'b1;
                    judge_flush = begin_flush;
                    judge_b = n_held[7:0];
                    n_held = '0;
                end else begin
                    n_phase = begin_flush ? PH_FLUSH_WAIT_ACK : PH_WAIT_ACK;
                end
            end else begin
                n_emit = '0;
                n_phase = begin_flush ? PH_FLUSH_SENDING : PH_SENDING;
            end
        end else begin
            seq_diff = 8'h00;
        end

        if (want_judge) begin
            if (judge_b == CH_ACK) begin
                n_ack = n_ack + 8'd1;
                n_emit = '0;
                n_phase = judge_flush ? PH_FLUSH_SENDING : PH_SENDING;
            end else begin
                do_idle = 1'b1;
                status = (judge_b == CH_CAN) ? ST_CANCELLED : ST_BAD_REPLY;
            end
        end

        if (do_idle) begin
            n_phase = (i_command == CMD_START) ? PH_WAIT_START : PH_IDLE;
            n_seq = 8'd1; n_ack = 8'd1;
            n_fill = '0; n_emit = '0; n_base = '0;
            n_size = i_block_1k ? BLK : SMALL_BLOCK;
            n_retry = '0; n_held = '0; n_eot = 2'd0;
        end

        // prefetch the byte that the next pull of a data position needs
        rd_full = {1'b0, n_base} + {1'b0, n_emit} - (CntW+1)'(3);

        o_result.tx_valid = tx_v;
        o_result.tx_byte  = tx_b;
        o_result.status   = status;
        o_result.crc_mode = n_crc;
    end

    assign o_rd_addr = rd_full[AW-1:0];
    assign o_wr_addr = r_fill[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_crc   <= 1'b0;
            r_seq   <= 8'd1;
            r_ack   <= 8'd1;
            r_fill  <= '0;
            r_emit  <= '0;
            r_base  <= '0;
            r_size  <= SMALL_BLOCK;
            r_check <= 16'h0000;
            r_retry <= '0;
            r_held  <= '0;
            r_eot   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_seq   <= n_seq;
            r_ack   <= n_ack;
            r_fill  <= n_fill;
            r_emit  <= n_emit;
            r_base  <= n_base;
            r_size  <= n_size;
            r_check <= n_check;
            r_retry <= n_retry;
            r_held  <= n_held;
            r_eot   <= n_eot;
        end
    end

endmodule

// ===== hw/rtl/xmodem_sender_framer_core.sv =====
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_command, i_rx_byte, i_data_byte
// result    out        o_out_valid / i_out_stall    o_tx_valid, o_tx_byte, o_status, o_crc_mode
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One command per cycle unless the input stalls: the controller updates its state and
// the result register in the command's cycle; the result appears in the cycle after.
// The block-store read is issued from the next emit position, so a pull finds its data
// byte already registered.
// Reset is synchronous, active low, and clears all control state; the store is not cleared.
// Input stalls only while a result sits unclaimed and the output is stalled.
module xmodem_sender_framer_core
    import xsf_pkg::*;
#(
    parameter int BLOCK_BYTES = BlockBytesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_rx_byte,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_tx_valid,
    output logic [7:0]         o_tx_byte,
    output logic [2:0]         o_status,
    output logic               o_crc_mode,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    localparam int AW = $clog2(BLOCK_BYTES);

    logic          r_block_1k;
    logic [4:0]    r_retry_limit;
    logic          r_out_valid;
    t_result       r_out, result;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;

    // hold the input while a result waits and the far side stalls
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_1k    <= 1'b0;
            r_retry_limit <= RETRY_DEF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BLOCK_1K: r_block_1k    <= i_cfg_data[0];
                REG_RETRY:    r_retry_limit <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    xsf_fsm #(.BLOCK_BYTES(BLOCK_BYTES)) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_rx_byte     (i_rx_byte),
        .i_block_1k    (r_block_1k),
        .i_retry_limit (r_retry_limit),
        .i_rd_data     (rd_data),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_result      (result)
    );

    xsf_store #(.BLOCK_BYTES(BLOCK_BYTES)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register: load on every transfer in, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_valid  = r_out.tx_valid;
    assign o_tx_byte   = r_out.tx_byte;
    assign o_status    = r_out.status;
    assign o_crc_mode  = r_out.crc_mode;

endmodule
